### src/rbsi_pkg.sv
// Shared types and constants for the ray/box slab intersection pipeline.
package rbsi_pkg;

  localparam int QW         = 32;        // Q16.16 word
  localparam int FRAC       = 16;        // fraction bits
  localparam int DW         = QW + 1;    // plane - origin, Q17.16
  localparam int PW         = 2 * QW;    // product, Q32.32 (fits since |d*s| < 2^63)
  localparam int PIPE_DEPTH = 6;         // register stages, input to output
  localparam int NUM_AXES   = 3;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;

  localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};

  // Pipeline advance control shared by all stages.
  typedef struct packed {
    logic adv;
  } pipe_ctl_t;

  // Floor to Q16.16 and clamp to the signed 32-bit range.
  function automatic q_t scale_sat(input prod_t p);
    logic signed [PW-FRAC-1:0] sh;
    q_t                        res;
    sh = p[PW-1:FRAC];
    if (!sh[PW-FRAC-1] && (|sh[PW-FRAC-2:QW-1])) begin
      res = Q_MAX;
    end else if (sh[PW-FRAC-1] && !(&sh[PW-FRAC-2:QW-1])) begin
      res = Q_MIN;
    end else begin
      res = sh[QW-1:0];
    end
    return res;
  endfunction

endpackage

### src/ray_box_slab_intersection.sv
// Top level of the fixed-point ray versus axis-aligned box slab test.
// Fully pipelined over six register stages: one item accepted per cycle while the
// pipe is not held, with the result valid on the outputs once it leaves the last stage.
// Stages: plane minus origin; 33x32 signed multiply per plane (six multipliers);
// floor to Q16.16 with saturation; per-axis sort; max of entries / min of exits;
// hit decision. The whole pipe holds when out_stall blocks a waiting result,
// and in_stall follows that hold; empty slots never stall the input.
module ray_box_slab_intersection
  import rbsi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  q_t   in_box_min_x,
  input  q_t   in_box_min_y,
  input  q_t   in_box_min_z,
  input  q_t   in_box_max_x,
  input  q_t   in_box_max_y,
  input  q_t   in_box_max_z,
  input  q_t   in_origin_x,
  input  q_t   in_origin_y,
  input  q_t   in_origin_z,
  input  q_t   in_inv_dir_x,
  input  q_t   in_inv_dir_y,
  input  q_t   in_inv_dir_z,
  output logic out_valid,
  input  logic out_stall,
  output logic out_hit,
  output q_t   out_t_entry,
  output q_t   out_t_exit
);

  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;
  pipe_ctl_t             ctl;

  q_t box_min  [NUM_AXES];
  q_t box_max  [NUM_AXES];
  q_t origin   [NUM_AXES];
  q_t inv_dir  [NUM_AXES];
  q_t near_dist[NUM_AXES];
  q_t far_dist [NUM_AXES];

  assign box_min = '{in_box_min_x, in_box_min_y, in_box_min_z};
  assign box_max = '{in_box_max_x, in_box_max_y, in_box_max_z};
  assign origin  = '{in_origin_x, in_origin_y, in_origin_z};
  assign inv_dir = '{in_inv_dir_x, in_inv_dir_y, in_inv_dir_z};

  // hold everything only while a finished result is refused
  assign ctl.adv  = !(vld_r[PIPE_DEPTH-1] && out_stall);
  assign in_stall = !ctl.adv;

  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.adv) begin
      vld_r <= vld_nxt;
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rbsi_slab_dist u_near (
      .clk      (clk),
      .ctl      (ctl),
      .plane    (box_min[a]),
      .org      (origin[a]),
      .inv      (inv_dir[a]),
      .distance (near_dist[a])
    );
    rbsi_slab_dist u_far (
      .clk      (clk),
      .ctl      (ctl),
      .plane    (box_max[a]),
      .org      (origin[a]),
      .inv      (inv_dir[a]),
      .distance (far_dist[a])
    );
  end

  rbsi_reduce u_reduce (
    .clk       (clk),
    .ctl       (ctl),
    .near_dist (near_dist),
    .far_dist  (far_dist),
    .hit       (out_hit),
    .t_entry   (out_t_entry),
    .t_exit    (out_t_exit)
  );

  assign out_valid = vld_r[PIPE_DEPTH-1];

`ifndef SYNTHESIS
  a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted input did not enter the pipe");

  a_hit_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit == (!out_t_exit[QW-1] && (out_t_exit >= out_t_entry))))
    else $error("hit flag disagrees with entry/exit distances");

  a_drain_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |-> !in_stall)
    else $error("input stalled while output transfer completes");
`endif

endmodule

### src/rbsi_slab_dist.sv
// One slab plane distance: subtract, multiply, scale and saturate over three stages.
module rbsi_slab_dist
  import rbsi_pkg::*;
(
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  q_t        plane,
  input  q_t        org,
  input  q_t        inv,
  output q_t        distance
);

  diff_t diff_r;
  q_t    inv_r;
  prod_t prod_r;
  q_t    dist_r;

  prod_t prod_full;

  // |diff * inv| < 2^63, so the signed 64-bit product is exact
  assign prod_full = prod_t'(diff_r) * prod_t'(inv_r);

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      diff_r <= diff_t'(plane) - diff_t'(org);
      inv_r  <= inv;
      prod_r <= prod_full;
      dist_r <= scale_sat(prod_r);
    end
  end

  assign distance = dist_r;

endmodule

### src/rbsi_reduce.sv
// Per-axis sort, cross-axis max/min and hit decision over three stages.
module rbsi_reduce
  import rbsi_pkg::*;
(
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  q_t        near_dist [NUM_AXES],
  input  q_t        far_dist  [NUM_AXES],
  output logic      hit,
  output q_t        t_entry,
  output q_t        t_exit
);

  q_t   lo_r [NUM_AXES];
  q_t   hi_r [NUM_AXES];
  q_t   entry_r;
  q_t   exit_r;
  q_t   entry_nxt;
  q_t   exit_nxt;
  logic hit_r;
  q_t   t_entry_r;
  q_t   t_exit_r;

  always_comb begin
    entry_nxt = lo_r[0];
    exit_nxt  = hi_r[0];
    for (int a = 1; a < NUM_AXES; a++) begin
      if (lo_r[a] > entry_nxt) begin
        entry_nxt = lo_r[a];
      end
      if (hi_r[a] < exit_nxt) begin
        exit_nxt = hi_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (near_dist[a] < far_dist[a]) begin
          lo_r[a] <= near_dist[a];
          hi_r[a] <= far_dist[a];
        end else begin
          lo_r[a] <= far_dist[a];
          hi_r[a] <= near_dist[a];
        end
      end
      entry_r   <= entry_nxt;
      exit_r    <= exit_nxt;
      hit_r     <= !exit_r[QW-1] && (exit_r >= entry_r);
      t_entry_r <= entry_r;
      t_exit_r  <= exit_r;
    end
  end

  assign hit     = hit_r;
  assign t_entry = t_entry_r;
  assign t_exit  = t_exit_r;

endmodule
